// File: hw/rtl/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // One request in the queue: the 3x3 window after the pixel went in, and
  // where that pixel sits in the frame.
  typedef struct packed {
    logic [8:0][23:0] win;
    logic [15:0]      row;
    logic [15:0]      col;
    logic             r1;
    logic             r2;
    logic             c1;
    logic             c2;
    logic             rl;
    logic             cl;
  } job_t;

endpackage

// File: hw/rtl/rgb_median_3x3_filter.sv
`timescale 1ns / 1ps

// Streaming 3x3 median filter on RGB pixels in raster order. Each colour is
// filtered over the neighbourhood clipped to the frame, and a result comes
// out one row and one column behind the input, tagged with its position;
// one pixel gives 0, 1, 2 or 4 results. Pixels are taken one per clock
// while the four-entry queue between the line store and the median unit has
// room; results leave at one per clock while out_stall is low, so a pixel
// that gives several results sends them in turn. Writing either size
// register restarts the frame at pixel (0,0); write only while idle.
module rgb_median_3x3_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [15:0] out_row,
  output logic [9:0]  out_col,
  output logic        run_last,
  output logic        frame_end
);

  logic                      push;
  logic                      pop;
  logic                      head_valid;
  rmf_pkg::job_t             push_job;
  rmf_pkg::job_t             head;
  logic [rmf_pkg::CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  rmf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (rmf_pkg::cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    ({red_in, green_in, blue_in}),
    .q_count   (q_count),
    .push      (push),
    .job       (push_job)
  );

  rmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  rmf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

endmodule

// File: hw/rtl/rmf_front.sv
`timescale 1ns / 1ps

module rmf_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  rmf_pkg::cfg_idx_t           cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [23:0]                 in_pix,
  input  logic [rmf_pkg::CNT_W-1:0]   q_count,
  output logic                        push,
  output rmf_pkg::job_t               job
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [10:0]      width_reg;
  logic [15:0]      height_reg;
  logic [15:0]      eff_w;
  logic [15:0]      eff_h;
  logic [AW-1:0]    col;
  logic [15:0]      row;
  logic [15:0]      col16;
  logic             col_end;
  logic             row_end;
  logic             accept;

  logic [23:0]      mem_a [MAX_WIDTH];
  logic [23:0]      mem_b [MAX_WIDTH];
  logic [23:0]      rd_a;
  logic [23:0]      rd_b;

  logic             f1_valid;
  logic [23:0]      f1_pix;
  logic [AW-1:0]    f1_col;
  logic [15:0]      f1_row;
  logic             f1_r1, f1_r2, f1_c1, f1_c2, f1_rl, f1_cl;

  logic [8:0][23:0] win;
  logic [8:0][23:0] win_next;

  always_comb begin
    if (width_reg == 11'd0) begin
      eff_w = 16'd1;
    end else if ({5'd0, width_reg} > 16'(MAX_WIDTH)) begin
      eff_w = 16'(MAX_WIDTH);
    end else begin
      eff_w = {5'd0, width_reg};
    end
    eff_h = (height_reg == 16'd0) ? 16'd1 : height_reg;
  end

  assign col16   = 16'(col);
  assign col_end = (col16 == eff_w - 16'd1);
  assign row_end = (row == eff_h - 16'd1);

  // The pixel in the first stage may be pushed on the next edge, so it
  // needs a free slot of its own.
  assign in_stall = ({1'b0, q_count} + 4'(f1_valid)) >= 4'(rmf_pkg::DEPTH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd1;
      height_reg <= 16'd1;
      col        <= '0;
      row        <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rmf_pkg::CFG_WIDTH:  width_reg  <= cfg_data[10:0];
        rmf_pkg::CFG_HEIGHT: height_reg <= cfg_data;
      endcase
      col <= '0;
      row <= 16'd0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Line store: the read is taken when a pixel is accepted, the write back
  // happens in the cycle after. With a single column the same address comes
  // round at once, so the values being written are forwarded.
  always_ff @(posedge clk) begin
    if (f1_valid) begin
      mem_a[f1_col] <= rd_b;
      mem_b[f1_col] <= f1_pix;
    end
    if (accept) begin
      if (f1_valid && f1_col == col) begin
        rd_a <= rd_b;
        rd_b <= f1_pix;
      end else begin
        rd_a <= mem_a[col];
        rd_b <= mem_b[col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    if (accept) begin
      f1_pix <= in_pix;
      f1_col <= col;
      f1_row <= row;
      f1_r1  <= (row != 16'd0);
      f1_r2  <= (row >= 16'd2);
      f1_c1  <= (col16 != 16'd0);
      f1_c2  <= (col16 >= 16'd2);
      f1_rl  <= row_end;
      f1_cl  <= col_end;
    end
  end

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = rd_a;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = rd_b;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = f1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (f1_valid) begin
      win <= win_next;
    end
  end

  assign push    = f1_valid && (f1_r1 || f1_rl) && (f1_c1 || f1_cl);
  assign job.win = win_next;
  assign job.row = f1_row;
  assign job.col = 16'(f1_col);
  assign job.r1  = f1_r1;
  assign job.r2  = f1_r2;
  assign job.c1  = f1_c1;
  assign job.c2  = f1_c2;
  assign job.rl  = f1_rl;
  assign job.cl  = f1_cl;

endmodule

// File: hw/rtl/rmf_queue.sv
`timescale 1ns / 1ps

module rmf_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rmf_pkg::job_t             push_job,
  input  logic                      pop,
  output rmf_pkg::job_t             head,
  output logic                      head_valid,
  output logic [rmf_pkg::CNT_W-1:0] count
);

  rmf_pkg::job_t               entries [rmf_pkg::DEPTH];
  logic [rmf_pkg::PTR_W-1:0]   wr_ptr;
  logic [rmf_pkg::PTR_W-1:0]   rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rmf_pkg::CNT_W'(rmf_pkg::DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == rmf_pkg::CNT_W'(rmf_pkg::DEPTH) |-> !push || pop)
    else $error("push into a full queue");

endmodule

// File: hw/rtl/rmf_back.sv
`timescale 1ns / 1ps

module rmf_back (
  input  logic          clk,
  input  logic          rst,
  input  rmf_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    red_out,
  output logic [7:0]    green_out,
  output logic [7:0]    blue_out,
  output logic [15:0]   out_row,
  output logic [9:0]    out_col,
  output logic          run_last,
  output logic          frame_end
);

  // Picks the value whose rank among the valid entries is count/2; equal
  // values are ranked by position so exactly one entry matches.
  function automatic logic [7:0] median9(input logic [8:0][7:0] v, input logic [8:0] msk);
    logic [3:0] n;
    logic [3:0] rank;
    logic [7:0] res;
    n   = 4'd0;
    res = 8'd0;
    for (int f = 0; f < 9; f++) begin
      n = n + 4'(msk[f]);
    end
    for (int e = 0; e < 9; e++) begin
      rank = 4'd0;
      for (int f = 0; f < 9; f++) begin
        if (msk[f] && (v[f] < v[e] || (v[f] == v[e] && f < e))) begin
          rank = rank + 4'd1;
        end
      end
      if (msk[e] && rank == (n >> 1)) begin
        res = v[e];
      end
    end
    return res;
  endfunction

  logic             mid;
  logic             rowopt;
  logic             colopt;
  logic             cur_row;
  logic             cur_col;
  logic             load;
  logic             done;
  logic [2:0]       rowok;
  logic [2:0]       colok;
  logic [8:0]       mask;
  logic [8:0][7:0]  rv, gv, bv;

  assign cur_row = mid ? rowopt : !head.r1;
  assign cur_col = mid ? colopt : !head.c1;
  assign load    = head_valid && (!out_valid || !out_stall);
  assign done    = !((!cur_col && head.cl) || (!cur_row && head.rl));
  assign pop     = load && done;

  always_comb begin
    rowok[0] = !cur_row && head.r2;
    rowok[1] = head.r1;
    rowok[2] = 1'b1;
    colok[0] = !cur_col && head.c2;
    colok[1] = head.c1;
    colok[2] = 1'b1;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        mask[k*3+m] = rowok[k] && colok[m];
      end
    end
    for (int e = 0; e < 9; e++) begin
      rv[e] = head.win[e][23:16];
      gv[e] = head.win[e][15:8];
      bv[e] = head.win[e][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid    <= 1'b0;
      rowopt <= 1'b0;
      colopt <= 1'b0;
    end else if (load) begin
      if (!cur_col && head.cl) begin
        mid    <= 1'b1;
        rowopt <= cur_row;
        colopt <= 1'b1;
      end else if (!cur_row && head.rl) begin
        mid    <= 1'b1;
        rowopt <= 1'b1;
        colopt <= !head.c1;
      end else begin
        mid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
    if (load) begin
      red_out   <= median9(rv, mask);
      green_out <= median9(gv, mask);
      blue_out  <= median9(bv, mask);
      out_row   <= cur_row ? head.row : head.row - 16'd1;
      out_col   <= cur_col ? head.col[9:0] : head.col[9:0] - 10'd1;
      run_last  <= done;
      frame_end <= done && head.rl && head.cl;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("frame end without run last");

  a_pop_on_load: assert property (@(posedge clk) disable iff (rst)
    pop |-> load && head_valid)
    else $error("request retired without a result");

endmodule
